>>> sv/ipsp_pkg.sv
// Package for the IR pulse symbol packer: beat payload types and constants.
// No dependencies; every other file in this folder uses it by scoped names.

package ipsp_pkg;

   // Longest half of a symbol, in ticks.
   localparam logic [14:0] CHUNK_MAX = 15'h7FFF;

   typedef struct packed {
      logic [15:0] duration;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        symbol_valid;
      logic        level_first;
      logic [14:0] duration_first;
      logic        level_second;
      logic [14:0] duration_second;
      logic        end_of_packet;
   } rsp_type;

endpackage

>>> sv/ir_pulse_symbol_packer.sv
// A timing beat's first symbol is offered at the edge that loads the result register
// from the input register; a full result buffer can hold the beat in between.
// Throughput: one timing beat per cycle while each gives at most one symbol and each
// result is taken; a beat that gives two symbols fills the two-entry result buffer.
// Synchronous active-high reset clears level parity, held phase, phase count
// and both registers' valid state. Uses ipsp_pkg.

module ir_pulse_symbol_packer #(
   parameter int MAX_PHASES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ipsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ipsp_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_PHASES + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_PHASES);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   ipsp_pkg::req_type in_data_ff;

   // Packet state.
   logic              parity_ff, parity_in;
   logic              held_valid_ff, held_valid_in;
   logic              held_level_ff, held_level_in;
   logic [14:0]       held_dur_ff, held_dur_in;
   logic [CW-1:0]     count_ff, count_in;

   // Two-entry result buffer.
   ipsp_pkg::rsp_type out0_ff, out0_in, out1_ff, out1_in;
   logic [1:0]        cnt_ff, cnt_in;

   logic              pop, buf_free, advance;
   logic [1:0]        n_chunks, n_take;
   logic [CW-1:0]     avail;
   logic [15:0]       dur;
   logic [14:0]       chunk_dur [3];
   logic              level;
   logic [14:0]       pdur [4];
   logic              plev [4];
   logic [2:0]        np;
   logic [1:0]        nres;
   ipsp_pkg::rsp_type r0, r1;
   logic [15:0]       over;

   assign pop      = (cnt_ff != 2'd0) && rsp_ready;
   assign buf_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign advance  = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = out0_ff;

   // Split the timing value into up to three phases.
   always_comb begin
      dur   = in_data_ff.duration;
      over  = dur - 16'd32767;
      level = ~parity_ff;
      chunk_dur[0] = dur[15] ? ipsp_pkg::CHUNK_MAX : dur[14:0];
      chunk_dur[1] = (dur == 16'hFFFF) ? ipsp_pkg::CHUNK_MAX : over[14:0];
      chunk_dur[2] = 15'd1;
      if (dur == 16'd0) begin
         n_chunks = 2'd0;
      end else if (!dur[15]) begin
         n_chunks = 2'd1;
      end else if (dur == 16'hFFFF) begin
         n_chunks = 2'd3;
      end else begin
         n_chunks = 2'd2;
      end
      avail = CAP - count_ff;
      if (avail >= CW'(3) || avail[1:0] >= n_chunks) begin
         n_take = n_chunks;
      end else begin
         n_take = avail[1:0];
      end
   end

   // Line up the held phase and the new phases, then pair them.
   always_comb begin
      if (held_valid_ff) begin
         plev[0] = held_level_ff;
         pdur[0] = held_dur_ff;
         for (int k = 1; k < 4; k++) begin
            plev[k] = level;
            pdur[k] = chunk_dur[k-1];
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            plev[k] = level;
            pdur[k] = chunk_dur[k];
         end
         plev[3] = 1'b0;
         pdur[3] = '0;
      end
      np = {2'b00, held_valid_ff} + {1'b0, n_take};

      r0 = '0;
      r1 = '0;
      nres = np[2:1];
      if (np >= 3'd2) begin
         r0 = '{1'b1, plev[0], pdur[0], plev[1], pdur[1], 1'b0};
      end
      if (np == 3'd4) begin
         r1 = '{1'b1, plev[2], pdur[2], plev[3], pdur[3], 1'b0};
      end
      // An odd phase on the last beat goes out with an empty second half.
      if (np[0] && in_data_ff.last) begin
         if (np == 3'd1) begin
            r0 = '{1'b1, plev[0], pdur[0], 1'b0, 15'd0, 1'b0};
         end else begin
            r1 = '{1'b1, plev[2], pdur[2], 1'b0, 15'd0, 1'b0};
         end
         nres = nres + 2'd1;
      end
      if (in_data_ff.last) begin
         unique case (nres)
            2'd0: begin
               r0 = '0;
               r0.end_of_packet = 1'b1;
               nres = 2'd1;
            end
            2'd1: r0.end_of_packet = 1'b1;
            default: r1.end_of_packet = 1'b1;
         endcase
      end
   end

   // Next state.
   always_comb begin
      in_valid_in   = in_valid_ff;
      parity_in     = parity_ff;
      held_valid_in = held_valid_ff;
      held_level_in = held_level_ff;
      held_dur_in   = held_dur_ff;
      count_in      = count_ff;
      out0_in       = out0_ff;
      out1_in       = out1_ff;
      cnt_in        = cnt_ff;

      if (req_ready) begin
         in_valid_in = req_valid;
      end

      if (advance) begin
         out0_in = r0;
         out1_in = r1;
         cnt_in  = nres;
         if (in_data_ff.last) begin
            parity_in     = 1'b0;
            held_valid_in = 1'b0;
            held_level_in = 1'b0;
            held_dur_in   = '0;
            count_in      = '0;
         end else begin
            parity_in     = ~parity_ff;
            count_in      = count_ff + CW'(n_take);
            held_valid_in = np[0];
            if (np[0]) begin
               held_level_in = np[1] ? plev[2] : plev[0];
               held_dur_in   = np[1] ? pdur[2] : pdur[0];
            end else begin
               held_level_in = 1'b0;
               held_dur_in   = '0;
            end
         end
      end else if (pop) begin
         out0_in = out1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         parity_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         held_level_ff <= 1'b0;
         held_dur_ff   <= '0;
         count_ff      <= '0;
         cnt_ff        <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         parity_ff     <= parity_in;
         held_valid_ff <= held_valid_in;
         held_level_ff <= held_level_in;
         held_dur_ff   <= held_dur_in;
         count_ff      <= count_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule

>>> sv/ipsp_checker.sv
// Port-level checks for the IR pulse symbol packer, bound to its top level.
// Uses ipsp_pkg and ir_pulse_symbol_packer.

module ipsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ipsp_pkg::rsp_type rsp_data
);

   // Reset leaves no result pending and the input side open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input blocked after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   // A result without a symbol is the packet terminator with all fields clear.
   a_terminator: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.symbol_valid) |->
         (rsp_data.end_of_packet && !rsp_data.level_first &&
          rsp_data.duration_first == 15'd0 && !rsp_data.level_second &&
          rsp_data.duration_second == 15'd0))
      else $error("malformed terminator beat");

   // Phases are never empty; an empty second half only pads the packet end.
   a_padding: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.symbol_valid) |->
         (rsp_data.duration_first != 15'd0 &&
          (rsp_data.duration_second != 15'd0 ||
           (rsp_data.end_of_packet && !rsp_data.level_second))))
      else $error("empty half outside packet end");

endmodule

bind ir_pulse_symbol_packer ipsp_checker u_ipsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/ir_pulse_symbol_packer_tb.sv
// Self-checking testbench for ir_pulse_symbol_packer: directed and random IR timing packets
// are checked against an in-bench symbol predictor, with random stalls on both sides.
// Depends on ipsp_pkg and ir_pulse_symbol_packer.

module ir_pulse_symbol_packer_tb;

   localparam int PHASE_LIMIT = 1024;
   localparam int TARGET_BEATS = 1400;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic              drain_first;
      ipsp_pkg::req_type beat;
   } timing_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ipsp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ipsp_pkg::rsp_type rsp_data;

   // Predictor state for the packet in progress.
   logic        space_next = 1'b0;
   logic        carry_valid = 1'b0;
   logic        carry_level = 1'b0;
   logic [14:0] carry_ticks = '0;
   int          phases_taken = 0;

   timing_item_type   pending[$];
   ipsp_pkg::rsp_type symbols_due[$];
   timing_item_type   next_item;
   ipsp_pkg::rsp_type want;

   bit req_taken = 1'b0;
   bit long_done = 1'b0;
   int tx_gap = 0;
   int tx_calm = 0;
   int rx_stall = 0;
   int rx_calm = 0;
   int hold_left = 0;
   int holds_done = 0;
   int failures = 0;
   int cycle_count = 0;
   int beats_in = 0;
   int results_seen = 0;
   int packets_done = 0;
   int empty_ends = 0;
   int capped_beats = 0;
   int queued = 0;
   int plen;
   int k;

   ir_pulse_symbol_packer #(.MAX_PHASES(PHASE_LIMIT)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic ipsp_pkg::rsp_type make_symbol(input logic valid, input logic lev0,
         input logic [14:0] ticks0, input logic lev1, input logic [14:0] ticks1);
      ipsp_pkg::rsp_type sym;
      sym = '0;
      sym.symbol_valid = valid;
      sym.level_first = lev0;
      sym.duration_first = ticks0;
      sym.level_second = lev1;
      sym.duration_second = ticks1;
      return sym;
   endfunction

   // Splits one timing value into phases, pairs them with any carried phase and
   // queues the symbols this beat must produce.
   function automatic void pack_timing(input ipsp_pkg::req_type beat);
      logic [15:0]       left;
      logic [14:0]       piece;
      logic              lvl;
      logic              part_level[4];
      logic [14:0]       part_ticks[4];
      ipsp_pkg::rsp_type made[2];
      int                n;
      int                nmade;
      int                i;
      left = beat.duration;
      lvl = ~space_next;
      n = 0;
      nmade = 0;
      if (carry_valid) begin
         part_level[0] = carry_level;
         part_ticks[0] = carry_ticks;
         n = 1;
      end
      while (left != 0 && phases_taken < PHASE_LIMIT) begin
         piece = (left > ipsp_pkg::CHUNK_MAX) ? ipsp_pkg::CHUNK_MAX : left[14:0];
         part_level[n] = lvl;
         part_ticks[n] = piece;
         n++;
         phases_taken++;
         left = left - piece;
      end
      if (left != 0)
         capped_beats++;
      space_next = ~space_next;
      for (i = 0; i + 1 < n; i += 2) begin
         made[nmade] = make_symbol(1'b1, part_level[i], part_ticks[i],
                                   part_level[i + 1], part_ticks[i + 1]);
         nmade++;
      end
      carry_valid = 1'b0;
      carry_level = 1'b0;
      carry_ticks = '0;
      if (i < n) begin
         if (beat.last) begin
            made[nmade] = make_symbol(1'b1, part_level[i], part_ticks[i], 1'b0, '0);
            nmade++;
         end else begin
            carry_valid = 1'b1;
            carry_level = part_level[i];
            carry_ticks = part_ticks[i];
         end
      end
      if (beat.last) begin
         if (nmade > 0) begin
            made[nmade - 1].end_of_packet = 1'b1;
         end else begin
            made[0] = make_symbol(1'b0, 1'b0, '0, 1'b0, '0);
            made[0].end_of_packet = 1'b1;
            nmade = 1;
            empty_ends++;
         end
         packets_done++;
         space_next = 1'b0;
         phases_taken = 0;
      end
      for (i = 0; i < nmade; i++)
         symbols_due.push_back(made[i]);
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none at all.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_ticks();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'd0;
      if (r < 22) begin
         case ($urandom_range(0, 4))
            0: return 16'd1;
            1: return 16'd32767;
            2: return 16'd32768;
            3: return 16'd65534;
            default: return 16'd65535;
         endcase
      end
      if (r < 60)
         return 16'($urandom_range(1, 2000));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic add_timing(input logic [15:0] ticks, input logic is_last, input logic drain);
      timing_item_type item;
      item.drain_first = drain;
      item.beat.duration = ticks;
      item.beat.last = is_last;
      pending.push_back(item);
      queued++;
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_val,
         input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         failures++;
      end
   endtask

   // Sender: a new beat goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending.size() == 0
                      || (pending[0].drain_first && symbols_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_item = pending.pop_front();
            req_data <= next_item.beat;
            req_valid <= 1'b1;
            tx_gap = pick_gap(tx_calm);
         end
      end
      req_taken = 1'b0;
   end

   // Receiver: random stalls plus two long hold-offs that back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if ((holds_done == 0 && results_seen >= 100)
                   || (holds_done == 1 && results_seen >= 700)) begin
         hold_left = LONG_HOLD - 1;
         holds_done++;
         rsp_ready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rx_stall = pick_gap(rx_calm);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pack_timing(req_data);
            req_taken = 1'b1;
            beats_in++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (symbols_due.size() == 0) begin
               $error("result beat with no symbol expected");
               failures++;
            end else begin
               want = symbols_due.pop_front();
               check_field("symbol_valid", 16'(want.symbol_valid),
                           16'(rsp_data.symbol_valid));
               check_field("level_first", 16'(want.level_first), 16'(rsp_data.level_first));
               check_field("duration_first", 16'(want.duration_first),
                           16'(rsp_data.duration_first));
               check_field("level_second", 16'(want.level_second),
                           16'(rsp_data.level_second));
               check_field("duration_second", 16'(want.duration_second),
                           16'(rsp_data.duration_second));
               check_field("end_of_packet", 16'(want.end_of_packet),
                           16'(rsp_data.end_of_packet));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      // Empty packet, a lone mark, and a full-scale value that splits three ways.
      add_timing(16'd0, 1'b1, 1'b0);
      add_timing(16'd1, 1'b1, 1'b0);
      add_timing(16'd65535, 1'b1, 1'b0);
      add_timing(16'd32767, 1'b0, 1'b0);
      add_timing(16'd32768, 1'b1, 1'b0);
      // A zero space still flips the level.
      add_timing(16'd100, 1'b0, 1'b0);
      add_timing(16'd0, 1'b0, 1'b0);
      add_timing(16'd200, 1'b1, 1'b0);
      // A last beat with nothing left to pair still sends a terminator after symbols went out.
      add_timing(16'd100, 1'b0, 1'b0);
      add_timing(16'd200, 1'b0, 1'b0);
      add_timing(16'd0, 1'b1, 1'b0);
      add_timing(16'd0, 1'b0, 1'b0);
      add_timing(16'd0, 1'b0, 1'b0);
      add_timing(16'd0, 1'b1, 1'b0);
      add_timing(16'hAAAA, 1'b0, 1'b0);
      add_timing(16'h5555, 1'b0, 1'b0);
      add_timing(16'h8000, 1'b0, 1'b0);
      add_timing(16'h7FFF, 1'b0, 1'b0);
      add_timing(16'h0001, 1'b1, 1'b0);
      add_timing(16'd65534, 1'b0, 1'b0);
      add_timing(16'd2, 1'b1, 1'b0);

      // Random packets; one long packet of large values runs past the phase limit.
      while (queued < TARGET_BEATS) begin
         if (!long_done && queued > 500) begin
            for (k = 0; k < 520; k++)
               add_timing(16'($urandom_range(32768, 65535)), k == 519, k == 0);
            long_done = 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 80)
               plen = $urandom_range(1, 8);
            else
               plen = $urandom_range(9, 40);
            for (k = 0; k < plen; k++)
               add_timing(pick_ticks(), k == plen - 1,
                          k == 0 && (queued == 21 || $urandom_range(0, 99) < 4));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid)
         @(posedge clock);
      while (symbols_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d timing beats in %0d packets; checked %0d result beats, %0d empty ends.",
               beats_in, packets_done, results_seen, empty_ends);
      $display("Phase limit cut %0d beats; receiver held off %0d times for %0d cycles.",
               capped_beats, holds_done, LONG_HOLD);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/ipsp_pkg.sv
sv/ir_pulse_symbol_packer.sv
sv/ipsp_checker.sv
dv/ir_pulse_symbol_packer_tb.sv
